// ===== rtl/fchc_pkg.sv =====
// Shared types and constants for the FIFO chunk hysteresis control block.
// No dependencies; every other rtl file imports this package.
`timescale 1ns / 1ps

package fchc_pkg;

    // Default width of the fill level input.
    localparam int FILL_BITS_DEF = 16;

    // Width of every configuration register and time counter.
    localparam int REG_W = 16;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Saturation value of the millisecond counters.
    localparam logic [REG_W-1:0] SAT_MAX = '1;

    // Request command codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_WATER     = 3'd0,
        REG_HIGH_WATER    = 3'd1,
        REG_NORMAL_CHUNK  = 3'd2,
        REG_REDUCED_CHUNK = 3'd3,
        REG_MIN_DWELL     = 3'd4,
        REG_IDLE_TIMEOUT  = 3'd5,
        REG_STATS_IVL     = 3'd6
    } cfg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [REG_W-1:0] LOW_WATER_RST     = 16'd4096;
    localparam logic [REG_W-1:0] HIGH_WATER_RST    = 16'd8192;
    localparam logic [REG_W-1:0] NORMAL_CHUNK_RST  = 16'd960;
    localparam logic [REG_W-1:0] REDUCED_CHUNK_RST = 16'd480;
    localparam logic [REG_W-1:0] MIN_DWELL_RST     = 16'd120;
    localparam logic [REG_W-1:0] IDLE_TIMEOUT_RST  = 16'd1000;
    localparam logic [REG_W-1:0] STATS_IVL_RST     = 16'd500;

    // Stream event codes reported with each poll result.
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_RESUMED = 2'd1,
        EV_IDLE    = 2'd2
    } stream_event_t;

    // Current configuration as seen by the decision logic.
    typedef struct packed {
        logic [REG_W-1:0] low_water;
        logic [REG_W-1:0] high_water;
        logic [REG_W-1:0] normal_chunk;
        logic [REG_W-1:0] reduced_chunk;
        logic [REG_W-1:0] min_dwell;
        logic [REG_W-1:0] idle_timeout;
        logic [REG_W-1:0] stats_ivl;
    } cfg_t;

    // One poll result.
    typedef struct packed {
        logic [REG_W-1:0] drain_len;
        logic             reduced_mode;
        logic             mode_switched;
        logic             streaming;
        stream_event_t    stream_event;
        logic             stats_pulse;
    } res_t;

endpackage

// ===== rtl/fifo_chunk_hysteresis_control.sv =====
// Channel   Handshake          Payload
// s_        s_valid/s_ready    s_cmd, s_fill_level[FILL_BITS-1:0]
// m_        m_valid/m_ready    m_drain_len, m_reduced_mode, m_mode_switched,
//                              m_streaming, m_stream_event, m_stats_pulse
// cfg_      cfg_wr_en          cfg_index, cfg_wdata
//
// One request is accepted per cycle while s_ready is high. A tick retires in
// the cycle after it is accepted and gives no result; a poll waits in the
// input register until the result register is free; m_valid rises on that load.
// Reset loads the register defaults, normal mode and an active stream.
// While m_ready is low the result holds and one more request waits in the
// input register; s_ready drops only when a poll is stuck behind a result.
`timescale 1ns / 1ps

module fifo_chunk_hysteresis_control
    import fchc_pkg::*;
#(
    parameter int FILL_BITS = FILL_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [FILL_BITS-1:0] s_fill_level,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [REG_W-1:0]     m_drain_len,
    output logic                 m_reduced_mode,
    output logic                 m_mode_switched,
    output logic                 m_streaming,
    output logic [1:0]           m_stream_event,
    output logic                 m_stats_pulse,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata
);

    cfg_t cfg;
    res_t res;
    logic res_load;
    logic res_free;

    // Configuration registers.
    fchc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input register, state and decision logic.
    fchc_core #(
        .FILL_BITS (FILL_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_fill_level (s_fill_level),
        .cfg          (cfg),
        .res_free     (res_free),
        .res_load     (res_load),
        .res          (res)
    );

    // Result register.
    fchc_out u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .res_load        (res_load),
        .res             (res),
        .res_free        (res_free),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drain_len     (m_drain_len),
        .m_reduced_mode  (m_reduced_mode),
        .m_mode_switched (m_mode_switched),
        .m_streaming     (m_streaming),
        .m_stream_event  (m_stream_event),
        .m_stats_pulse   (m_stats_pulse)
    );

endmodule

// ===== rtl/fchc_cfg.sv =====
// Configuration register file for the FIFO chunk hysteresis control block.
// Depends on fchc_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module fchc_cfg
    import fchc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; an index past the last register changes nothing.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                REG_LOW_WATER:     cfg_next.low_water     = cfg_wdata;
                REG_HIGH_WATER:    cfg_next.high_water    = cfg_wdata;
                REG_NORMAL_CHUNK:  cfg_next.normal_chunk  = cfg_wdata;
                REG_REDUCED_CHUNK: cfg_next.reduced_chunk = cfg_wdata;
                REG_MIN_DWELL:     cfg_next.min_dwell     = cfg_wdata;
                REG_IDLE_TIMEOUT:  cfg_next.idle_timeout  = cfg_wdata;
                REG_STATS_IVL:     cfg_next.stats_ivl     = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_water     <= LOW_WATER_RST;
            cfg_reg.high_water    <= HIGH_WATER_RST;
            cfg_reg.normal_chunk  <= NORMAL_CHUNK_RST;
            cfg_reg.reduced_chunk <= REDUCED_CHUNK_RST;
            cfg_reg.min_dwell     <= MIN_DWELL_RST;
            cfg_reg.idle_timeout  <= IDLE_TIMEOUT_RST;
            cfg_reg.stats_ivl     <= STATS_IVL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/fchc_core.sv =====
// Input register, drain state and per-request decision logic of the
// FIFO chunk hysteresis control block. Depends on fchc_pkg.
`timescale 1ns / 1ps

module fchc_core
    import fchc_pkg::*;
#(
    parameter int FILL_BITS = FILL_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [FILL_BITS-1:0] s_fill_level,
    input  cfg_t                 cfg,
    input  logic                 res_free,
    output logic                 res_load,
    output res_t                 res
);

    // Compare width: wide enough for both the fill level and a register.
    localparam int CMP_W = (FILL_BITS > REG_W) ? FILL_BITS : REG_W;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic                 cmd_reg;
    logic [FILL_BITS-1:0] fill_reg;

    logic             reduced_reg;
    logic             reduced_next;
    logic [REG_W-1:0] since_switch_reg;
    logic [REG_W-1:0] since_switch_next;
    logic [REG_W-1:0] since_data_reg;
    logic [REG_W-1:0] since_data_next;
    logic             streaming_reg;
    logic             streaming_next;
    logic [REG_W-1:0] stats_cnt_reg;
    logic [REG_W-1:0] stats_cnt_next;

    logic             fire;
    logic             poll_fire;
    logic [CMP_W-1:0] fill_ext;
    logic [CMP_W-1:0] chunk_ext;
    logic [REG_W-1:0] chunk;
    logic [REG_W-1:0] rd;
    logic             may_switch;
    logic             go_reduced;
    logic             go_normal;
    logic             switched;
    logic             resumed;
    logic             went_idle;
    logic [REG_W-1:0] stats_base;
    logic             pulse;

    // A tick always retires; a poll retires when the result register is free.
    assign fire      = in_valid_reg && ((cmd_reg == CMD_TICK) || res_free);
    assign poll_fire = fire && (cmd_reg == CMD_POLL);
    assign s_ready   = !in_valid_reg || fire;
    assign in_valid_next = s_valid ? 1'b1 : (in_valid_reg && !fire);

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg  <= s_cmd;
            fill_reg <= s_fill_level;
        end
    end

    // Watermark hysteresis with a minimum dwell between switches.
    always_comb begin
        fill_ext   = CMP_W'(fill_reg);
        may_switch = since_switch_reg >= cfg.min_dwell;
        go_reduced = may_switch && !reduced_reg && (fill_ext < CMP_W'(cfg.low_water));
        go_normal  = may_switch && reduced_reg && (fill_ext > CMP_W'(cfg.high_water));
        switched   = go_reduced || go_normal;
        reduced_next = go_reduced || (reduced_reg && !go_normal);
    end

    // Read amount is the smaller of the fill and the chosen chunk.
    always_comb begin
        chunk     = reduced_next ? cfg.reduced_chunk : cfg.normal_chunk;
        chunk_ext = CMP_W'(chunk);
        rd        = (fill_ext < chunk_ext) ? fill_ext[REG_W-1:0] : chunk;
    end

    // Idle detection, resume and the periodic statistics counter.
    always_comb begin
        resumed   = (rd != '0) && !streaming_reg;
        went_idle = (rd == '0) && streaming_reg && (since_data_reg > cfg.idle_timeout);
        streaming_next = resumed || (streaming_reg && !went_idle);
        stats_base = resumed ? '0 : stats_cnt_reg;
        pulse      = streaming_next && (stats_base >= cfg.stats_ivl);
        if (!streaming_next) begin
            stats_cnt_next = stats_cnt_reg;
        end else if (pulse) begin
            stats_cnt_next = '0;
        end else begin
            stats_cnt_next = stats_base + 1'b1;
        end
    end

    // Tick-advanced saturating millisecond counters, cleared by a switch or a read.
    always_comb begin
        if (cmd_reg == CMD_TICK) begin
            since_switch_next = (since_switch_reg == SAT_MAX) ? SAT_MAX
                                                              : since_switch_reg + 1'b1;
            since_data_next   = (since_data_reg == SAT_MAX) ? SAT_MAX
                                                            : since_data_reg + 1'b1;
        end else begin
            since_switch_next = switched ? '0 : since_switch_reg;
            since_data_next   = (rd != '0) ? '0 : since_data_reg;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reduced_reg      <= 1'b0;
            since_switch_reg <= '0;
            since_data_reg   <= '0;
            streaming_reg    <= 1'b1;
            stats_cnt_reg    <= '0;
        end else if (fire) begin
            since_switch_reg <= since_switch_next;
            since_data_reg   <= since_data_next;
            if (cmd_reg == CMD_POLL) begin
                reduced_reg   <= reduced_next;
                streaming_reg <= streaming_next;
                stats_cnt_reg <= stats_cnt_next;
            end
        end
    end

    // Result handed to the output register.
    always_comb begin
        res.drain_len     = rd;
        res.reduced_mode  = reduced_next;
        res.mode_switched = switched;
        res.streaming     = streaming_next;
        if (resumed) begin
            res.stream_event = EV_RESUMED;
        end else if (went_idle) begin
            res.stream_event = EV_IDLE;
        end else begin
            res.stream_event = EV_NONE;
        end
        res.stats_pulse   = pulse;
    end

    assign res_load = poll_fire;

`ifndef SYNTHESIS
    // A mode switch restarts the dwell timer.
    a_switch_clears_dwell: assert property (@(posedge aclk) disable iff (!aresetn)
        poll_fire && res.mode_switched |=> since_switch_reg == '0)
        else $error("dwell timer not cleared after a mode switch");

    // A switch is only taken once the dwell time has passed.
    a_switch_after_dwell: assert property (@(posedge aclk) disable iff (!aresetn)
        poll_fire && res.mode_switched |-> since_switch_reg >= cfg.min_dwell)
        else $error("mode switched before the dwell time");

    // A resume always leaves the stream active.
    a_resume_streams: assert property (@(posedge aclk) disable iff (!aresetn)
        poll_fire && res.stream_event == EV_RESUMED |-> res.streaming)
        else $error("resume reported without streaming");

    // A statistics pulse restarts the poll counter.
    a_pulse_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        poll_fire && res.stats_pulse |=> stats_cnt_reg == '0)
        else $error("stats counter not cleared after a pulse");

    // The read amount never exceeds the chosen chunk.
    a_read_within_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        poll_fire |-> res.drain_len <= chunk)
        else $error("read amount larger than the chunk");
`endif

endmodule

// ===== rtl/fchc_out.sv =====
// Result register of the FIFO chunk hysteresis control block.
// Depends on fchc_pkg for res_t.
`timescale 1ns / 1ps

module fchc_out
    import fchc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_load,
    input  res_t             res,
    output logic             res_free,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [REG_W-1:0] m_drain_len,
    output logic             m_reduced_mode,
    output logic             m_mode_switched,
    output logic             m_streaming,
    output logic [1:0]       m_stream_event,
    output logic             m_stats_pulse
);

    logic m_valid_reg;
    logic m_valid_next;
    res_t res_reg;

    // The register is free when empty or when its request leaves this cycle.
    assign res_free     = !m_valid_reg || m_ready;
    assign m_valid_next = res_load ? 1'b1 : (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

    // Drive the result ports.
    assign m_valid         = m_valid_reg;
    assign m_drain_len     = res_reg.drain_len;
    assign m_reduced_mode  = res_reg.reduced_mode;
    assign m_mode_switched = res_reg.mode_switched;
    assign m_streaming     = res_reg.streaming;
    assign m_stream_event  = res_reg.stream_event;
    assign m_stats_pulse   = res_reg.stats_pulse;

endmodule

// ===== dv/fifo_chunk_hysteresis_control_test.sv =====
// Self-checking testbench for fifo_chunk_hysteresis_control: directed and random requests
// against a cycle-free predictor of the drain decision, with random stalls on both channels.
// Depends on fchc_pkg and the block's rtl only.
`timescale 1ns / 1ps

module fifo_chunk_hysteresis_control_test;
    import fchc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD = 300;
    localparam int QUIET_CYCLES = 4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic                     cmd;
        logic [FILL_BITS_DEF-1:0] fill;
    } drain_req_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_cmd = CMD_TICK;
    logic [FILL_BITS_DEF-1:0] s_fill_level = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [REG_W-1:0]         m_drain_len;
    logic                     m_reduced_mode;
    logic                     m_mode_switched;
    logic                     m_streaming;
    logic [1:0]               m_stream_event;
    logic                     m_stats_pulse;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [REG_W-1:0]         cfg_wdata = '0;

    fifo_chunk_hysteresis_control uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_fill_level    (s_fill_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drain_len     (m_drain_len),
        .m_reduced_mode  (m_reduced_mode),
        .m_mode_switched (m_mode_switched),
        .m_streaming     (m_streaming),
        .m_stream_event  (m_stream_event),
        .m_stats_pulse   (m_stats_pulse),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Pending requests, expected drain results and bookkeeping.
    drain_req_t req_queue[$];
    res_t       due_reads[$];
    int         queued_reqs = 0;
    int         accepted_reqs = 0;
    int         mismatches = 0;
    int         cycle_cnt = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         long_hold_req = 1'b0;
    int         hold_cnt = 0;
    drain_req_t next_req;

    // Predictor copy of the configuration and the drain state.
    cfg_t shadow_cfg = '{LOW_WATER_RST, HIGH_WATER_RST, NORMAL_CHUNK_RST, REDUCED_CHUNK_RST,
                         MIN_DWELL_RST, IDLE_TIMEOUT_RST, STATS_IVL_RST};
    logic             red_mode = 1'b0;
    logic [REG_W-1:0] ms_since_switch = '0;
    logic [REG_W-1:0] ms_since_data = '0;
    logic             stream_on = 1'b1;
    logic [REG_W-1:0] stats_cnt = '0;

    // Coverage tallies for the summary.
    int n_polls = 0;
    int n_ticks = 0;
    int n_switches = 0;
    int n_idle = 0;
    int n_resumes = 0;
    int n_pulses = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        mismatches++;
    endtask

    // Apply one accepted request to the predictor; a poll leaves one expected result.
    function automatic void predict_drain(input logic cmd, input logic [FILL_BITS_DEF-1:0] fill);
        logic [REG_W-1:0] chunk;
        logic [REG_W-1:0] rd;
        logic             may_switch;
        res_t             r;
        if (cmd == CMD_TICK) begin
            n_ticks++;
            if (ms_since_switch != SAT_MAX) ms_since_switch++;
            if (ms_since_data != SAT_MAX) ms_since_data++;
            return;
        end
        n_polls++;
        r = '0;
        r.stream_event = EV_NONE;
        may_switch = (ms_since_switch >= shadow_cfg.min_dwell);
        if (may_switch && !red_mode && fill < shadow_cfg.low_water) begin
            red_mode = 1'b1;
            ms_since_switch = '0;
            r.mode_switched = 1'b1;
        end else if (may_switch && red_mode && fill > shadow_cfg.high_water) begin
            red_mode = 1'b0;
            ms_since_switch = '0;
            r.mode_switched = 1'b1;
        end
        chunk = red_mode ? shadow_cfg.reduced_chunk : shadow_cfg.normal_chunk;
        rd = (fill < chunk) ? fill : chunk;
        if (rd != '0) begin
            ms_since_data = '0;
            if (!stream_on) begin
                stream_on = 1'b1;
                r.stream_event = EV_RESUMED;
                stats_cnt = '0;
            end
        end else if (stream_on && ms_since_data > shadow_cfg.idle_timeout) begin
            stream_on = 1'b0;
            r.stream_event = EV_IDLE;
        end
        if (stream_on) begin
            if (stats_cnt >= shadow_cfg.stats_ivl) begin
                r.stats_pulse = 1'b1;
                stats_cnt = '0;
            end else begin
                stats_cnt++;
            end
        end
        r.drain_len = rd;
        r.reduced_mode = red_mode;
        r.streaming = stream_on;
        if (r.mode_switched) n_switches++;
        if (r.stream_event == EV_IDLE) n_idle++;
        if (r.stream_event == EV_RESUMED) n_resumes++;
        if (r.stats_pulse) n_pulses++;
        due_reads.insert(due_reads.size(), r);
    endfunction

    // Request driver: holds each request until it is taken, then maybe idles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_drain(s_cmd, s_fill_level);
                accepted_reqs++;
            end
            if (!s_valid || s_ready) begin
                if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = req_queue.pop_front();
                    s_valid <= 1'b1;
                    s_cmd <= next_req.cmd;
                    s_fill_level <= next_req.fill;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Length of the long receiver hold-off, counted in cycles.
    always @(posedge aclk) begin
        if (long_hold_req && hold_cnt < LONG_HOLD) begin
            hold_cnt <= hold_cnt + 1;
        end
    end

    // Result monitor: compares each taken result with the oldest expectation.
    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_reads.size() == 0) begin
                    report_mismatch("result with no poll outstanding");
                end else begin
                    want = due_reads.pop_front();
                    if (m_drain_len !== want.drain_len)
                        report_mismatch($sformatf("drain_len %0d, expected %0d",
                                                  m_drain_len, want.drain_len));
                    if (m_reduced_mode !== want.reduced_mode)
                        report_mismatch($sformatf("reduced_mode %b, expected %b",
                                                  m_reduced_mode, want.reduced_mode));
                    if (m_mode_switched !== want.mode_switched)
                        report_mismatch($sformatf("mode_switched %b, expected %b",
                                                  m_mode_switched, want.mode_switched));
                    if (m_streaming !== want.streaming)
                        report_mismatch($sformatf("streaming %b, expected %b",
                                                  m_streaming, want.streaming));
                    if (m_stream_event !== want.stream_event)
                        report_mismatch($sformatf("stream_event %0d, expected %0d",
                                                  m_stream_event, want.stream_event));
                    if (m_stats_pulse !== want.stats_pulse)
                        report_mismatch($sformatf("stats_pulse %b, expected %b",
                                                  m_stats_pulse, want.stats_pulse));
                end
            end
            // A long hold-off lets the block back up into its input.
            if (long_hold_req && hold_cnt < LONG_HOLD) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[fifo_chunk_hysteresis_control] ERROR");
            $finish;
        end
    end

    task automatic queue_req(input logic cmd, input logic [FILL_BITS_DEF-1:0] fill);
        drain_req_t r;
        r.cmd = cmd;
        r.fill = fill;
        req_queue.insert(req_queue.size(), r);
        queued_reqs++;
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) queue_req(CMD_TICK, '0);
    endtask

    // Wait until every request is taken and every result is back, and until a trailing
    // tick has retired.
    task automatic wait_quiet();
        @(posedge aclk);
        while (accepted_reqs != queued_reqs || due_reads.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // Register write; the predictor copy follows. Unknown indexes are dropped.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_LOW_WATER:     shadow_cfg.low_water = val;
            REG_HIGH_WATER:    shadow_cfg.high_water = val;
            REG_NORMAL_CHUNK:  shadow_cfg.normal_chunk = val;
            REG_REDUCED_CHUNK: shadow_cfg.reduced_chunk = val;
            REG_MIN_DWELL:     shadow_cfg.min_dwell = val;
            REG_IDLE_TIMEOUT:  shadow_cfg.idle_timeout = val;
            REG_STATS_IVL:     shadow_cfg.stats_ivl = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [REG_W-1:0] clamp16(input int v);
        if (v < 0) return '0;
        if (v > 65535) return SAT_MAX;
        return v[REG_W-1:0];
    endfunction

    // One random block: a fresh setting with short times, then mostly ticks and
    // polls whose fill is near a watermark, zero, all ones, up to 1000 or random.
    task automatic random_block(input int n_items);
        int lo;
        int hi;
        int pushed;
        int pick;
        int burst;
        logic [REG_W-1:0] fill;
        lo = $urandom_range(0, 3000);
        hi = lo + $urandom_range(0, 3000);
        // Now and then the watermarks cross each other.
        if ($urandom_range(7) == 0) begin
            pick = lo;
            lo = hi;
            hi = pick;
        end
        write_reg(REG_LOW_WATER, clamp16(lo));
        write_reg(REG_HIGH_WATER, clamp16(hi));
        write_reg(REG_NORMAL_CHUNK, ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(1, 2000)));
        write_reg(REG_REDUCED_CHUNK, ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(1, 1000)));
        write_reg(REG_MIN_DWELL, 16'($urandom_range(0, 15)));
        write_reg(REG_IDLE_TIMEOUT, 16'($urandom_range(0, 30)));
        write_reg(REG_STATS_IVL, 16'($urandom_range(0, 12)));
        end_writes();
        pushed = 0;
        while (pushed < n_items) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                queue_req(CMD_TICK, 16'($urandom));
                pushed++;
            end else if (pick < 40) begin
                burst = $urandom_range(5, 40);
                queue_ticks(burst);
                pushed += burst;
            end else begin
                case ($urandom_range(6))
                    0: fill = clamp16(lo + $urandom_range(0, 6) - 3);
                    1: fill = clamp16(hi + $urandom_range(0, 6) - 3);
                    2: fill = '0;
                    3: fill = 16'($urandom_range(0, 1000));
                    4: fill = SAT_MAX;
                    default: fill = 16'($urandom);
                endcase
                queue_req(CMD_POLL, fill);
                pushed++;
            end
        end
        wait_quiet();
    endtask

    initial begin
        // Reset once, with sender and receiver in the first idling mode.
        send_idle_pct = 20;
        recv_idle_pct = 56;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: dwell blocking a switch, both switches and the high
        // watermark edge.
        queue_req(CMD_POLL, 16'd0);
        queue_req(CMD_POLL, SAT_MAX);
        queue_ticks(120);
        queue_req(CMD_POLL, 16'd100);
        queue_req(CMD_POLL, 16'd9000);
        queue_ticks(120);
        queue_req(CMD_POLL, 16'd8192);
        queue_req(CMD_POLL, 16'd8193);
        queue_req(CMD_POLL, 16'd0);
        queue_req(CMD_POLL, 16'd0);
        queue_req(CMD_POLL, 16'd5);
        wait_quiet();

        // Zero normal chunk, zero timeout, a stats pulse on each streaming poll; also a write
        // to the unused index that must change nothing.
        write_reg(REG_LOW_WATER, 16'd0);
        write_reg(REG_HIGH_WATER, SAT_MAX);
        write_reg(REG_NORMAL_CHUNK, 16'd0);
        write_reg(REG_REDUCED_CHUNK, SAT_MAX);
        write_reg(REG_MIN_DWELL, 16'd0);
        write_reg(REG_IDLE_TIMEOUT, 16'd0);
        write_reg(REG_STATS_IVL, 16'd0);
        write_reg(REG_UNUSED, 16'd1);
        end_writes();
        queue_req(CMD_POLL, SAT_MAX);
        queue_ticks(1);
        queue_req(CMD_POLL, 16'd1);
        queue_req(CMD_POLL, 16'd0);
        wait_quiet();
        write_reg(REG_NORMAL_CHUNK, SAT_MAX);
        end_writes();
        queue_req(CMD_POLL, SAT_MAX);
        queue_req(CMD_POLL, 16'd0);
        wait_quiet();

        // Watermarks at the top of the range and the longest stats interval.
        write_reg(REG_LOW_WATER, SAT_MAX);
        write_reg(REG_STATS_IVL, SAT_MAX);
        end_writes();
        queue_req(CMD_POLL, 16'hFFFE);
        queue_req(CMD_POLL, SAT_MAX);
        wait_quiet();

        // The longest dwell blocks every switch and the longest timeout keeps
        // the stream active through empty polls.
        write_reg(REG_LOW_WATER, 16'd100);
        write_reg(REG_HIGH_WATER, 16'd200);
        write_reg(REG_NORMAL_CHUNK, 16'd50);
        write_reg(REG_REDUCED_CHUNK, 16'd50);
        write_reg(REG_MIN_DWELL, SAT_MAX);
        write_reg(REG_IDLE_TIMEOUT, SAT_MAX);
        write_reg(REG_STATS_IVL, 16'd3);
        end_writes();
        queue_ticks(20);
        queue_req(CMD_POLL, 16'd0);
        wait_quiet();
        write_reg(REG_IDLE_TIMEOUT, 16'hFFFE);
        end_writes();
        queue_req(CMD_POLL, 16'd0);
        queue_req(CMD_POLL, 16'd300);
        wait_quiet();

        // Random part; the first block starts with a long receiver hold-off.
        long_hold_req = 1'b1;
        random_block(170);
        send_idle_pct = 56;
        recv_idle_pct = 20;
        random_block(170);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_block(170);

        wait_quiet();
        repeat (10) @(posedge aclk);
        if (due_reads.size() != 0)
            report_mismatch($sformatf("%0d poll results never arrived", due_reads.size()));
        $display("run covered %0d polls and %0d ticks under several register settings",
                 n_polls, n_ticks);
        $display("seen: %0d mode switches, %0d idle, %0d resumes, %0d stats pulses",
                 n_switches, n_idle, n_resumes, n_pulses);
        if (mismatches == 0) begin
            $display("[fifo_chunk_hysteresis_control] OK");
        end else begin
            $display("[fifo_chunk_hysteresis_control] ERROR");
        end
        $finish;
    end

endmodule
